// ----- rtl/pvd_pkg.sv -----
// Package for the prefix varint decoder: field widths, code length limits
// and the helper functions for the first-byte length count and value masks.
// No dependencies.
`timescale 1ns / 1ps

package pvd_pkg;

  localparam int BYTE_W       = 8;
  localparam int VALUE_W      = 64;
  localparam int LEN_W        = 4;
  localparam int CODE_MAX_LEN = 9;
  localparam int BITS_PER_LEN = 7;

  localparam logic [LEN_W-1:0] LEN_ONE = LEN_W'(1);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(CODE_MAX_LEN);

  // Leading ones of the first byte plus one; all ones gives nine.
  function automatic logic [LEN_W-1:0] length_of_first(input logic [BYTE_W-1:0] b);
    logic [LEN_W-1:0] n;
    logic             run;
    n   = LEN_ONE;
    run = 1'b1;
    for (int i = BYTE_W - 1; i >= 0; i--) begin
      run = run & b[i];
      if (run) begin
        n = n + LEN_ONE;
      end
    end
    return n;
  endfunction

  // Keep the low 7 * len bits; nine bytes and above keep the whole word.
  function automatic logic [VALUE_W-1:0] length_mask(input logic [LEN_W-1:0] len);
    logic [VALUE_W-1:0] m;
    case (len)
      4'd1:    m = (VALUE_W'(1) << (1 * BITS_PER_LEN)) - VALUE_W'(1);
      4'd2:    m = (VALUE_W'(1) << (2 * BITS_PER_LEN)) - VALUE_W'(1);
      4'd3:    m = (VALUE_W'(1) << (3 * BITS_PER_LEN)) - VALUE_W'(1);
      4'd4:    m = (VALUE_W'(1) << (4 * BITS_PER_LEN)) - VALUE_W'(1);
      4'd5:    m = (VALUE_W'(1) << (5 * BITS_PER_LEN)) - VALUE_W'(1);
      4'd6:    m = (VALUE_W'(1) << (6 * BITS_PER_LEN)) - VALUE_W'(1);
      4'd7:    m = (VALUE_W'(1) << (7 * BITS_PER_LEN)) - VALUE_W'(1);
      4'd8:    m = (VALUE_W'(1) << (8 * BITS_PER_LEN)) - VALUE_W'(1);
      default: m = '1;
    endcase
    return m;
  endfunction

endpackage

// ----- rtl/pvd_channels.sv -----
// Stream channel interfaces of the prefix varint decoder: the byte input
// channel and the decoded result channel. Depends on pvd_pkg.
`timescale 1ns / 1ps

interface pvd_byte_if;
  logic                        valid;
  logic                        ready;
  logic [pvd_pkg::BYTE_W-1:0]  data_byte;
  logic                        last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface pvd_result_if;
  logic                        valid;
  logic                        ready;
  logic [pvd_pkg::VALUE_W-1:0] value;
  logic [pvd_pkg::LEN_W-1:0]   code_length;
  logic                        truncated;

  modport source (output valid, output value, output code_length, output truncated,
                  input ready);
  modport sink   (input valid, input value, input code_length, input truncated,
                  output ready);
endinterface

// ----- rtl/prefix_varint_decoder.sv -----
// Prefix varint decoder top level: accumulator, length tracking and result
// register. Depends on pvd_pkg and the channel interfaces in pvd_channels.sv.
`timescale 1ns / 1ps

// Takes one byte per cycle and emits one result per completed code (1 to 9
// bytes) or per code cut off by last_byte. A result appears in the result
// register the cycle after the final byte of its code; the byte channel is
// ready whenever that register is empty or is being taken, so a stream with
// a ready sink runs at one byte per clock. The path per byte is the
// leading-ones count, an 8-bit shift into the 64-bit accumulator, a mask
// and the optional sign unfold. signed_mode is sampled at code completion.

module prefix_varint_decoder (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data,
  pvd_byte_if.sink            byte_stream,
  pvd_result_if.source        result
);

  logic                          signed_mode;
  logic [pvd_pkg::VALUE_W-1:0]   accumulator;
  logic [pvd_pkg::LEN_W-1:0]     expected_length;
  logic [pvd_pkg::LEN_W-1:0]     bytes_taken;
  logic                          out_valid;
  logic [pvd_pkg::VALUE_W-1:0]   out_value;
  logic [pvd_pkg::LEN_W-1:0]     out_length;
  logic                          out_truncated;

  logic                          accept;
  logic                          first;
  logic [pvd_pkg::LEN_W-1:0]     len_cur;
  logic [pvd_pkg::VALUE_W-1:0]   accumulator_next;
  logic [pvd_pkg::LEN_W-1:0]     bytes_taken_next;
  logic                          complete;
  logic [pvd_pkg::VALUE_W-1:0]   masked;
  logic [pvd_pkg::VALUE_W-1:0]   unfolded;
  logic [pvd_pkg::VALUE_W-1:0]   decoded;

  assign byte_stream.ready  = !out_valid || result.ready;
  assign accept             = byte_stream.valid && byte_stream.ready;
  assign result.valid       = out_valid;
  assign result.value       = out_value;
  assign result.code_length = out_length;
  assign result.truncated   = out_truncated;

  always_comb begin
    first = (expected_length == '0);
    if (first) begin
      len_cur          = pvd_pkg::length_of_first(byte_stream.data_byte);
      accumulator_next = pvd_pkg::VALUE_W'(byte_stream.data_byte);
      bytes_taken_next = pvd_pkg::LEN_ONE;
    end else begin
      len_cur          = expected_length;
      accumulator_next = {accumulator[pvd_pkg::VALUE_W-pvd_pkg::BYTE_W-1:0],
                          byte_stream.data_byte};
      bytes_taken_next = bytes_taken + pvd_pkg::LEN_ONE;
    end
    complete = (bytes_taken_next >= len_cur);
    masked   = accumulator_next & pvd_pkg::length_mask(len_cur);
    unfolded = {1'b0, masked[pvd_pkg::VALUE_W-1:1]};
    if (signed_mode && masked[0]) begin
      decoded = ~unfolded;
    end else if (signed_mode) begin
      decoded = unfolded;
    end else begin
      decoded = masked;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      signed_mode <= 1'b0;
    end else if (cfg_wr_en) begin
      signed_mode <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_length <= '0;
      bytes_taken     <= '0;
      accumulator     <= '0;
    end else if (accept) begin
      if (complete || byte_stream.last_byte) begin
        expected_length <= '0;
        bytes_taken     <= '0;
        accumulator     <= '0;
      end else begin
        expected_length <= len_cur;
        bytes_taken     <= bytes_taken_next;
        accumulator     <= accumulator_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && (complete || byte_stream.last_byte)) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && complete) begin
      out_value     <= decoded;
      out_length    <= len_cur;
      out_truncated <= 1'b0;
    end else if (accept && byte_stream.last_byte) begin
      out_value     <= '0;
      out_length    <= '0;
      out_truncated <= 1'b1;
    end
  end

  a_taken_below_length: assert property (@(posedge clk) disable iff (rst)
    (expected_length != '0) |-> (bytes_taken < expected_length))
    else $error("bytes_taken reached expected_length without completing");

  a_truncated_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_truncated) |-> (out_length == '0 && out_value == '0))
    else $error("truncated result carries a length or value");

  a_length_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_truncated) |->
      (out_length >= pvd_pkg::LEN_ONE && out_length <= pvd_pkg::LEN_MAX))
    else $error("completed code length out of range");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && byte_stream.last_byte) |=> (expected_length == '0 && out_valid))
    else $error("buffer end did not close the code");

endmodule

// ----- verif/tb.sv -----
// Self-checking bench for prefix_varint_decoder: bursty byte traffic, a result
// sink with shifting stall styles, and a bit-exact decode predictor.
// Depends on pvd_pkg, pvd_channels.sv and the decoder RTL.
`timescale 1ns / 1ps

module tb;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 4;
  localparam int SHOWN_ERRORS = 10;

  typedef struct packed {
    logic [pvd_pkg::BYTE_W-1:0] data;
    logic                       last;
  } stream_byte_t;

  typedef struct packed {
    logic [pvd_pkg::VALUE_W-1:0] value;
    logic [pvd_pkg::LEN_W-1:0]   code_length;
    logic                        truncated;
  } decoded_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_PULSE, RX_SPARSE} rx_style_t;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic cfg_wr_data;

  pvd_byte_if   bs();
  pvd_result_if rs();

  prefix_varint_decoder dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .byte_stream (bs),
    .result      (rs)
  );

  stream_byte_t byte_q[$];
  decoded_t     decoded_q[$];
  stream_byte_t cur;
  decoded_t     want;

  // decode state of the predictor
  logic [pvd_pkg::VALUE_W-1:0] acc;
  int                          code_len;
  int                          got_len;
  logic                        signed_now;

  int  burst_left;
  int  gap_left;
  bit  take;
  int  cycles;
  int  errors;
  int  n_bytes;
  int  n_values;
  int  n_truncs;
  int  rx_count;
  rx_style_t rx_style;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int prefix_len(input logic [pvd_pkg::BYTE_W-1:0] b);
    int n;
    n = 1;
    while (n < pvd_pkg::CODE_MAX_LEN && b[pvd_pkg::BYTE_W - n]) n++;
    return n;
  endfunction

  function automatic void decode_byte(input stream_byte_t it);
    logic [pvd_pkg::VALUE_W-1:0] v;
    logic                        sgn;
    decoded_t                    d;
    if (code_len == 0) begin
      code_len = prefix_len(it.data);
      acc      = pvd_pkg::VALUE_W'(it.data);
      got_len  = 1;
    end else begin
      acc     = {acc[pvd_pkg::VALUE_W-pvd_pkg::BYTE_W-1:0], it.data};
      got_len = got_len + 1;
    end
    if (got_len >= code_len) begin
      v = acc;
      if (code_len < pvd_pkg::CODE_MAX_LEN) begin
        v = v & ((pvd_pkg::VALUE_W'(1) << (code_len * pvd_pkg::BITS_PER_LEN))
                 - pvd_pkg::VALUE_W'(1));
      end
      if (signed_now) begin
        sgn = v[0];
        v   = v >> 1;
        if (sgn) begin
          v = ~v;
        end
      end
      d.value       = v;
      d.code_length = pvd_pkg::LEN_W'(code_len);
      d.truncated   = 1'b0;
      decoded_q.push_back(d);
      code_len = 0;
      got_len  = 0;
      acc      = '0;
    end else if (it.last) begin
      d.value       = '0;
      d.code_length = '0;
      d.truncated   = 1'b1;
      decoded_q.push_back(d);
      code_len = 0;
      got_len  = 0;
      acc      = '0;
    end
  endfunction

  function automatic void push_byte(input logic [pvd_pkg::BYTE_W-1:0] data, input logic last);
    stream_byte_t it;
    it.data = data;
    it.last = last;
    byte_q.push_back(it);
  endfunction

  // emit the first count bytes of a len-byte code, random payload
  function automatic void push_code(input int len, input int count, input logic end_last);
    logic [pvd_pkg::BYTE_W-1:0] hi;
    logic [pvd_pkg::BYTE_W-1:0] lo;
    hi = 8'hFF << (pvd_pkg::CODE_MAX_LEN - len);
    lo = 8'($urandom) & (8'hFF >> len);
    if (len == pvd_pkg::CODE_MAX_LEN) begin
      hi = 8'hFF;
      lo = 8'h00;
    end
    push_byte(hi | lo, end_last && count == 1);
    for (int i = 1; i < count; i++) begin
      push_byte(8'($urandom), end_last && i == count - 1);
    end
  endfunction

  function automatic void queue_directed();
    push_byte(8'h00, 1'b0);
    push_byte(8'h7F, 1'b0);
    push_byte(8'hFF, 1'b0);
    for (int i = 0; i < 8; i++) push_byte(8'hFF, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFE, 1'b0);
    push_byte(8'h80, 1'b0);
    for (int i = 0; i < 5; i++) push_byte(8'h00, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'hE0, 1'b0);
    push_byte(8'h12, 1'b1);
    push_byte(8'hBF, 1'b0);
    push_byte(8'hFF, 1'b1);
  endfunction

  // mostly whole codes, some cut short by last_byte, some stray bytes
  function automatic void queue_random(input int n);
    int start;
    int len;
    int r;
    start = byte_q.size();
    while (byte_q.size() - start < n) begin
      r   = $urandom_range(0, 99);
      len = $urandom_range(1, pvd_pkg::CODE_MAX_LEN);
      if (r < 75) begin
        push_code(len, len, $urandom_range(0, 9) == 0);
      end else if (r < 90 && len > 1) begin
        push_code(len, $urandom_range(1, len - 1), 1'b1);
      end else begin
        push_byte(8'($urandom), $urandom_range(0, 7) == 0);
      end
    end
    // close the phase so the decoder is back at a code boundary
    push_byte(8'($urandom), 1'b1);
  endfunction

  task automatic note_error(input string what, input decoded_t exp_d, input decoded_t act_d);
    errors++;
    if (errors <= SHOWN_ERRORS) begin
      $display("%s: expected value=%h len=%0d trunc=%0d, got value=%h len=%0d trunc=%0d",
               what, exp_d.value, exp_d.code_length, exp_d.truncated,
               act_d.value, act_d.code_length, act_d.truncated);
    end
  endtask

  task automatic write_signed_mode(input logic m);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    signed_now  = m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic drain();
    while (!(byte_q.size() == 0 && !bs.valid && decoded_q.size() == 0)) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cur_result_check();
    decoded_t act_d;
    act_d.value       = rs.value;
    act_d.code_length = rs.code_length;
    act_d.truncated   = rs.truncated;
    if (act_d.truncated) n_truncs++;
    else n_values++;
    if (decoded_q.size() == 0) begin
      note_error("unexpected result", '0, act_d);
    end else begin
      want = decoded_q.pop_front();
      if (act_d.value !== want.value || act_d.code_length !== want.code_length ||
          act_d.truncated !== want.truncated) begin
        note_error("result mismatch", want, act_d);
      end
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      bs.valid   <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      take = bs.valid && bs.ready;
      if (take) begin
        decode_byte(cur);
        n_bytes++;
      end
      if (bs.valid && !take) begin
        // hold the offered byte
      end else if (gap_left > 0) begin
        gap_left  <= gap_left - 1;
        bs.valid  <= 1'b0;
      end else if (byte_q.size() > 0) begin
        cur = byte_q.pop_front();
        bs.valid     <= 1'b1;
        bs.data_byte <= cur.data;
        bs.last_byte <= cur.last;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        bs.valid <= 1'b0;
      end
    end
  end

  // result sink stall pattern
  always @(posedge clk) begin
    if (rst) begin
      rs.ready <= 1'b0;
      rx_count <= 0;
      rx_style <= RX_OPEN;
    end else begin
      rx_count <= rx_count + 1;
      if (rx_count % 64 == 63) begin
        rx_style <= rx_style_t'($urandom_range(0, 3));
      end
      case (rx_style)
        RX_OPEN:  rs.ready <= 1'b1;
        RX_COIN:  rs.ready <= 1'($urandom_range(0, 1));
        RX_PULSE: rs.ready <= (rx_count % 4 == 3);
        default:  rs.ready <= ($urandom_range(0, 9) == 0);
      endcase
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && rs.valid && rs.ready) begin
      cur_result_check();
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, decoded_q.size());
      $display("prefix_varint_decoder regression: fail");
      $finish;
    end
  end

  initial begin
    clk          = 1'b0;
    rst          = 1'b1;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = 1'b0;
    bs.valid     = 1'b0;
    bs.data_byte = '0;
    bs.last_byte = 1'b0;
    rs.ready     = 1'b0;
    cycles       = 0;
    errors       = 0;
    n_bytes      = 0;
    n_values     = 0;
    n_truncs     = 0;
    acc          = '0;
    code_len     = 0;
    got_len      = 0;
    signed_now   = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    for (int p = 0; p < 6; p++) begin
      write_signed_mode(1'(p % 2));
      if (p < 2) queue_directed();
      else queue_random(250);
      drain();
    end
    $display("%0d stream bytes in, %0d decoded values and %0d truncations checked,",
             n_bytes, n_values, n_truncs);
    $display("unsigned and signed decoding, code lengths 1 to 9, bursty input and stalls");
    if (errors == 0) begin
      $display("prefix_varint_decoder regression: pass");
    end else begin
      $display("%0d mismatches", errors);
      $display("prefix_varint_decoder regression: fail");
    end
    $finish;
  end

endmodule
